@@ hdl/b64d_pkg.sv @@
package b64d_pkg;

  // Width of the internal decoded-byte counter.
  localparam int unsigned COUNT_BITS = 16;

  // Pad character '=' and the width of one base64 digit.
  localparam logic [7:0] PAD_CHAR = 8'd61;
  localparam int unsigned SEXTET_BITS = 6;

  // Largest value the counter can hold.
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Reset value of the capacity register.
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // One character mapped through the alphabet.
  typedef struct packed {
    logic                   valid;
    logic [SEXTET_BITS-1:0] value;
  } sextet_t;

  // One result item as it sits in the output or skid register.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        done_res;
    logic        error;
    logic [15:0] byte_count;
  } result_t;

endpackage

@@ hdl/b64d_sextet_map.sv @@
module b64d_sextet_map (
  input  logic [7:0]        symbol,
  output b64d_pkg::sextet_t sextet
);
  import b64d_pkg::*;

  // Map one character of the standard alphabet to its 6-bit value.
  always_comb begin
    sextet.valid = 1'b1;
    sextet.value = '0;
    if (symbol inside {[8'd65:8'd90]}) begin
      sextet.value = SEXTET_BITS'(symbol - 8'd65);
    end else if (symbol inside {[8'd97:8'd122]}) begin
      sextet.value = SEXTET_BITS'(symbol - 8'd71);
    end else if (symbol inside {[8'd48:8'd57]}) begin
      sextet.value = SEXTET_BITS'(symbol + 8'd4);
    end else if (symbol == 8'd43) begin
      sextet.value = SEXTET_BITS'(62);
    end else if (symbol == 8'd47) begin
      sextet.value = SEXTET_BITS'(63);
    end else begin
      sextet.valid = 1'b0;
    end
  end

endmodule

@@ hdl/base64_stream_decoder.sv @@
// Each result item is registered, in the skid register first if the result register is held.
// Throughput: one input item per cycle; a result register plus a one-item skid register
// let the input keep flowing while a result waits, and in_stall rises only when both are full.
// Reset (rst, synchronous, active high) clears the stream state, empties both result registers,
// and sets output_capacity to 65535.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        done_res,
  output logic        error,
  output logic [15:0] byte_count
);
  import b64d_pkg::*;

  logic [15:0]           output_capacity;
  logic [1:0]            group_position, group_position_next;
  logic [5:0]            previous_sextet, previous_sextet_next;
  logic [1:0]            pad_count, pad_count_next;
  logic                  error_seen, error_seen_next;
  logic [COUNT_BITS-1:0] decoded_count, decoded_count_next;
  logic                  over_capacity, over_capacity_next;

  sextet_t sextet;
  result_t result, out_reg, skid;
  logic    skid_valid;
  logic    in_accept, has_result, out_free;
  logic    have_byte;
  logic [7:0] byte_value;
  logic [31:0] count_wide;

  b64d_sextet_map u_sextet_map (
    .symbol (symbol),
    .sextet (sextet)
  );

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAPACITY_RESET;
    end else if (cfg_write_en) begin
      output_capacity <= cfg_write_data;
    end
  end

  // Per-character decode and stream state update.
  always_comb begin
    group_position_next  = group_position + 2'd1;
    previous_sextet_next = previous_sextet;
    pad_count_next       = pad_count;
    error_seen_next      = error_seen;
    decoded_count_next   = decoded_count;
    over_capacity_next   = over_capacity;
    have_byte            = 1'b0;
    byte_value           = '0;

    if (symbol == PAD_CHAR) begin
      if (pad_count >= 2'd2) begin
        error_seen_next = 1'b1;
      end else begin
        pad_count_next = pad_count + 2'd1;
      end
    end else if (!sextet.valid || pad_count != 2'd0) begin
      error_seen_next = 1'b1;
    end else begin
      case (group_position)
        2'd1:    byte_value = {previous_sextet, sextet.value[5:4]};
        2'd2:    byte_value = {previous_sextet[3:0], sextet.value[5:2]};
        2'd3:    byte_value = {previous_sextet[1:0], sextet.value};
        default: byte_value = '0;
      endcase
      previous_sextet_next = sextet.value;
      if (group_position != 2'd0 && !error_seen) begin
        have_byte = 1'b1;
        if (32'(decoded_count) >= 32'(output_capacity)) begin
          over_capacity_next = 1'b1;
        end
        if (decoded_count != COUNT_MAX) begin
          decoded_count_next = decoded_count + 1'b1;
        end
      end
    end

    count_wide = 32'(decoded_count_next);

    // Build the result item for this character.
    has_result        = have_byte || last;
    result.data_byte  = have_byte ? byte_value : 8'd0;
    result.byte_valid = have_byte;
    result.done_res   = last;
    result.error      = last && (error_seen_next || over_capacity_next ||
                                 group_position_next != 2'd0);
    result.byte_count = !last ? 16'd0 :
                        (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];
  end

  // Stream state registers; the final character clears them for the next string.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position  <= '0;
      previous_sextet <= '0;
      pad_count       <= '0;
      error_seen      <= 1'b0;
      decoded_count   <= '0;
      over_capacity   <= 1'b0;
    end else if (in_accept) begin
      if (last) begin
        group_position  <= '0;
        previous_sextet <= '0;
        pad_count       <= '0;
        error_seen      <= 1'b0;
        decoded_count   <= '0;
        over_capacity   <= 1'b0;
      end else begin
        group_position  <= group_position_next;
        previous_sextet <= previous_sextet_next;
        pad_count       <= pad_count_next;
        error_seen      <= error_seen_next;
        decoded_count   <= decoded_count_next;
        over_capacity   <= over_capacity_next;
      end
    end
  end

  // Result register with a one-item skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept && has_result;
      end
    end else if (in_accept && has_result) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the two result registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid : result;
    end else if (in_accept && has_result) begin
      skid <= result;
    end
  end

  assign data_byte  = out_reg.data_byte;
  assign byte_valid = out_reg.byte_valid;
  assign done_res   = out_reg.done_res;
  assign error      = out_reg.error;
  assign byte_count = out_reg.byte_count;

  // The skid register only fills while the result register is held.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("skid register full while result register is empty");

  // Every presented result item carries a byte or the done status.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (byte_valid || done_res))
    else $error("empty result item presented");

  // Error and count are only reported with done.
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !done_res) |-> (!error && byte_count == 16'd0))
    else $error("status reported on a result item without done");

  // A held result item does not turn into a different one while stalled.
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> (out_valid && $stable(done_res) && $stable(data_byte)))
    else $error("result item changed while stalled");

endmodule
